// ===== rtl/core/sotf_pkg.sv =====
// ----------------------------------------------------------------------------
// sotf_pkg
// shared types and constants for the swap-to-front table
// ----------------------------------------------------------------------------
package sotf_pkg;

  localparam int unsigned ValueW = 32;  // width of a table entry
  localparam int unsigned PosW   = 8;   // width of the reported position
  localparam int unsigned CountW = 9;   // width of the reported entry count

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  // request token travelling down the row of cells
  typedef struct packed {
    logic              valid;
    op_e               op;
    logic              hit;   // an earlier cell already matched
    logic [ValueW-1:0] key;   // value appended or searched for
    logic [ValueW-1:0] head;  // slot 0 contents at the start of the pass
  } tok_t;

endpackage

// ===== rtl/core/sotf_cell.sv =====
// ----------------------------------------------------------------------------
// sotf_cell
// one table slot: holds an entry and forwards the request token
// ----------------------------------------------------------------------------
module sotf_cell
  import sotf_pkg::*;
#(
  parameter int unsigned IDX_W    = 8,
  parameter int unsigned CNT_W    = 9,
  parameter int unsigned CELL_IDX = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [CNT_W-1:0]  fill_i,
  input  tok_t              tok_i,
  input  logic [IDX_W-1:0]  pos_i,
  input  logic              wr_i,
  input  logic [ValueW-1:0] wr_data_i,
  output tok_t              tok_o,
  output logic [IDX_W-1:0]  pos_o,
  output logic [ValueW-1:0] entry_o
);

  logic [ValueW-1:0] entry_q, entry_d;
  tok_t              tok_q, tok_d;
  logic [IDX_W-1:0]  pos_q, pos_d;
  logic              occupied;
  logic              match;
  logic              app;

  assign occupied = CNT_W'(CELL_IDX) < fill_i;
  assign match    = tok_i.valid && (tok_i.op == OP_LOOKUP) && !tok_i.hit &&
                    occupied && (entry_q == tok_i.key);
  assign app      = tok_i.valid && (tok_i.op == OP_APPEND) &&
                    (fill_i == CNT_W'(CELL_IDX));

  always_comb begin
    entry_d = entry_q;
    if (wr_i) begin
      entry_d = wr_data_i;
    end else if (app) begin
      entry_d = tok_i.key;
    end else if (match) begin
      // swap partner: old head moves into this slot
      entry_d = tok_i.head;
    end
    tok_d     = tok_i;
    tok_d.hit = tok_i.hit | match;
    pos_d     = match ? IDX_W'(CELL_IDX) : pos_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      entry_q <= entry_d;
      pos_q   <= pos_d;
      tok_q   <= tok_d;
    end
  end

  // only the valid flag needs a defined reset value, kept apart for clarity
  logic vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= tok_d.valid;
    end
  end

  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = vld_q;
  end

  assign pos_o   = pos_q;
  assign entry_o = entry_q;

endmodule

// ===== rtl/core/self_organizing_swap_to_front_list.sv =====
// ----------------------------------------------------------------------------
// self_organizing_swap_to_front_list
// self-organising value table with append and swap-to-front lookup
// ----------------------------------------------------------------------------
// usage
//   input channel: op_i / value_i with in_valid_i, in_stall_o. op append puts
//   the value in the next free slot (overflow_o if full); op lookup searches
//   from slot 0 upward and swaps the first match with slot 0.
//   output channel: found_o / position_o / overflow_o / entry_count_o with
//   out_valid_o, out_stall_i; exactly one result per input transfer.
// flow
//   every item walks a token through the whole row of TABLE_DEPTH cells,
//   registered in each cell in turn, and then from the row end into the
//   output register; the block takes no new item until that token has left
//   the row, and the swap write into slot 0 happens as the result is
//   registered.
// reset
//   the entry count clears and no result is pending; entries are not cleared,
//   only slots below the count are ever compared.
// stall
//   a new item is taken while a result still waits in the output register;
//   if the token reaches the end while that result is still stalled, the
//   whole row freezes until the output register frees up.
// ----------------------------------------------------------------------------
module self_organizing_swap_to_front_list
  import sotf_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     op_i,
  input  logic signed [ValueW-1:0] value_i,
  // output channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     found_o,
  output logic [PosW-1:0]          position_o,
  output logic                     overflow_o,
  output logic [CountW-1:0]        entry_count_o
);

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  // token and position links between cells; link i feeds cell i
  tok_t             tok_link [TABLE_DEPTH+1];
  logic [IDX_W-1:0] pos_link [TABLE_DEPTH+1];

  logic [ValueW-1:0] head_entry;    // slot 0 contents
  logic              busy_q;        // an item is walking the row
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic              out_valid_q;
  logic              accept;
  logic              advance;
  logic              done;
  logic              full;
  logic              app_ok;
  logic              head_wr;
  tok_t              exit_tok;
  logic [IDX_W-1:0]  exit_pos;

  // result register contents
  logic              found_q;
  logic [PosW-1:0]   position_q;
  logic              overflow_q;
  logic [CountW-1:0] count_q;

  // width adaption of internal indexes to the reported fields
  logic [IDX_W+PosW-1:0]   pos_ext;
  logic [CNT_W+PosW-1:0]   fill_pos_ext;
  logic [CNT_W+CountW-1:0] cnt_ext;

  assign in_stall_o = busy_q;
  assign accept     = in_valid_i && !busy_q;

  assign exit_tok = tok_link[TABLE_DEPTH];
  assign exit_pos = pos_link[TABLE_DEPTH];

  // the row holds when a finished token cannot leave
  assign advance = !(exit_tok.valid && out_valid_q && out_stall_i);
  assign done    = exit_tok.valid && advance;

  assign full    = fill_q == CNT_W'(TABLE_DEPTH);
  assign app_ok  = (exit_tok.op == OP_APPEND) && !full;
  assign fill_d  = app_ok ? fill_q + CNT_W'(1) : fill_q;
  // completing the swap: the searched value lands in slot 0
  assign head_wr = done && exit_tok.hit;

  // token injected at the head of the row
  always_comb begin
    tok_link[0].valid = accept;
    tok_link[0].op    = op_e'(op_i);
    tok_link[0].hit   = 1'b0;
    tok_link[0].key   = value_i;
    tok_link[0].head  = head_entry;
    pos_link[0]       = '0;
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic [ValueW-1:0] entry;

    sotf_cell #(
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W),
      .CELL_IDX (i)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (advance),
      .fill_i    (fill_q),
      .tok_i     (tok_link[i]),
      .pos_i     (pos_link[i]),
      .wr_i      ((i == 0) ? head_wr : 1'b0),
      .wr_data_i (exit_tok.key),
      .tok_o     (tok_link[i+1]),
      .pos_o     (pos_link[i+1]),
      .entry_o   (entry)
    );

    if (i == 0) begin : g_head
      assign head_entry = entry;
    end
  end

  assign pos_ext      = (IDX_W + PosW)'(exit_pos);
  assign fill_pos_ext = (CNT_W + PosW)'(fill_q);
  assign cnt_ext      = (CNT_W + CountW)'(fill_d);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (done) begin
        busy_q <= 1'b0;
      end
      if (done) begin
        fill_q      <= fill_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (done) begin
      found_q    <= exit_tok.hit;
      overflow_q <= (exit_tok.op == OP_APPEND) && full;
      count_q    <= cnt_ext[CountW-1:0];
      if (exit_tok.hit) begin
        position_q <= pos_ext[PosW-1:0];
      end else if (app_ok) begin
        position_q <= fill_pos_ext[PosW-1:0];
      end else begin
        position_q <= '0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign position_o    = position_q;
  assign overflow_o    = overflow_q;
  assign entry_count_o = count_q;

endmodule
